// File: sv/sqs_pkg.sv
// Shared types and constants for the sample quartile selector.
package sqs_pkg;

    localparam int unsigned MAX_SAMPLES_DEF = 1024;
    localparam int unsigned SAMPLE_W        = 64;
    localparam int unsigned WHICH_W         = 2;

    // Result selector codes
    localparam logic [WHICH_W-1:0] WHICH_Q1     = 2'd0;
    localparam logic [WHICH_W-1:0] WHICH_MEDIAN = 2'd1;
    localparam logic [WHICH_W-1:0] WHICH_Q3     = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] quantile_value;
        logic [WHICH_W-1:0]  which;
        logic                overflow;
        logic                end_of_run;
    } t_out_item;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // insert the broadcast sample in order
        logic shift;  // move every value one cell toward the head
        logic clear;  // drop all held values
    } t_cell_ctl;

endpackage

// File: sv/sqs_cell.sv
// One insertion-sort cell: holds one value and trades with its neighbors.
module sqs_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sqs_pkg::t_cell_ctl            i_ctl,
    input  logic [sqs_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [sqs_pkg::SAMPLE_W-1:0]  i_prev_data,
    input  logic                          i_prev_gt,
    input  logic                          i_prev_valid,
    input  logic [sqs_pkg::SAMPLE_W-1:0]  i_next_data,
    output logic [sqs_pkg::SAMPLE_W-1:0]  o_data,
    output logic                          o_gt,
    output logic                          o_valid
);

    logic [sqs_pkg::SAMPLE_W-1:0] r_data;
    logic [sqs_pkg::SAMPLE_W-1:0] n_data;
    logic                         r_valid;
    logic                         n_valid;

    // An empty cell counts as larger than any sample
    assign o_gt    = !r_valid || (r_data > i_sample);
    assign o_data  = r_data;
    assign o_valid = r_valid;

    // Take the new sample at the insertion point, the left value above it
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.load) begin
            if (o_gt) begin
                n_data = i_prev_gt ? i_prev_data : i_sample;
            end
            n_valid = r_valid || i_prev_valid;
        end else if (i_ctl.shift) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

endmodule

// File: sv/sqs_chain.sv
// Row of sorting cells; the head cell holds the smallest value.
module sqs_chain #(
    parameter int unsigned NUM_CELLS = sqs_pkg::MAX_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sqs_pkg::t_cell_ctl            i_ctl,
    input  logic [sqs_pkg::SAMPLE_W-1:0]  i_sample,
    output logic [sqs_pkg::SAMPLE_W-1:0]  o_head
);

    logic [sqs_pkg::SAMPLE_W-1:0] w_data  [NUM_CELLS];
    logic                         w_gt    [NUM_CELLS];
    logic                         w_valid [NUM_CELLS];

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        logic [sqs_pkg::SAMPLE_W-1:0] w_prev_data;
        logic                         w_prev_gt;
        logic                         w_prev_valid;
        logic [sqs_pkg::SAMPLE_W-1:0] w_next_data;

        // Head cell sees a virtual smaller, valid neighbor on its left
        if (g == 0) begin : g_head
            assign w_prev_data  = '0;
            assign w_prev_gt    = 1'b0;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_data  = w_data[g-1];
            assign w_prev_gt    = w_gt[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == NUM_CELLS - 1) begin : g_tail
            assign w_next_data = '0;
        end else begin : g_inner
            assign w_next_data = w_data[g+1];
        end

        sqs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_sample     (i_sample),
            .i_prev_data  (w_prev_data),
            .i_prev_gt    (w_prev_gt),
            .i_prev_valid (w_prev_valid),
            .i_next_data  (w_next_data),
            .o_data       (w_data[g]),
            .o_gt         (w_gt[g]),
            .o_valid      (w_valid[g])
        );
    end

    assign o_head = w_data[0];

endmodule

// File: sv/sample_quartile_selector.sv
// Top level: sorting cell chain plus the run control and quartile readout.
// Load: one sample per cycle while busy is low; each is inserted in order in that cycle,
// or dropped and flagged as overflow once the chain is full. Readout: after the closing
// transaction busy stays high while the chain shifts toward the head; Q1, the median and
// Q3 follow in order, busy drops with Q3; results cannot be stalled by the receiver.
// Reset (synchronous, active low) empties the chain and clears count and overflow.
module sample_quartile_selector #(
    parameter int unsigned MAX_SAMPLES = sqs_pkg::MAX_SAMPLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  sqs_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_strobe,
    output sqs_pkg::t_out_item o_result
);

    localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);
    localparam int unsigned RNK_W = CNT_W + 2;

    typedef enum logic {S_LOAD, S_DRAIN} t_state;

    t_state                       r_state;
    logic [CNT_W-1:0]             r_count;
    logic                         r_drop;
    logic [IDX_W-1:0]             r_idx;
    logic [sqs_pkg::WHICH_W-1:0]  r_which;
    logic                         r_strobe;
    sqs_pkg::t_out_item           r_result;

    logic                         w_accept;
    logic                         w_room;
    logic                         w_hit;
    logic [RNK_W-1:0]             w_n;
    logic [RNK_W-1:0]             w_rank;
    sqs_pkg::t_cell_ctl           w_ctl;
    logic [sqs_pkg::SAMPLE_W-1:0] w_head;

    assign w_accept = start && (r_state == S_LOAD);
    assign w_room   = r_count < CNT_W'(MAX_SAMPLES);
    assign w_n      = RNK_W'(r_count);

    // Rank of the result in turn, counted from 1
    always_comb begin
        unique case (r_which)
            sqs_pkg::WHICH_Q1:     w_rank = (w_n + RNK_W'(3)) >> 2;
            sqs_pkg::WHICH_MEDIAN: w_rank = (w_n + RNK_W'(1)) >> 1;
            default:               w_rank = (w_n + (w_n << 1) + RNK_W'(3)) >> 2;
        endcase
    end

    assign w_hit = (r_state == S_DRAIN) && (RNK_W'(r_idx) == w_rank - RNK_W'(1));

    // Drive the chain: insert on load, shift toward the head while draining
    always_comb begin
        w_ctl.load  = w_accept && w_room;
        w_ctl.shift = (r_state == S_DRAIN) && !w_hit;
        w_ctl.clear = w_hit && (r_which == sqs_pkg::WHICH_Q3);
    end

    sqs_chain #(
        .NUM_CELLS (MAX_SAMPLES)
    ) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_item.sample),
        .o_head   (w_head)
    );

    // Run control, readout walk and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_idx    <= '0;
            r_which  <= sqs_pkg::WHICH_Q1;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_hit;
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_item.last) begin
                            r_state <= S_DRAIN;
                            r_idx   <= '0;
                            r_which <= sqs_pkg::WHICH_Q1;
                        end
                    end
                end
                S_DRAIN: begin
                    if (w_hit) begin
                        if (r_which == sqs_pkg::WHICH_Q3) begin
                            r_state <= S_LOAD;
                            r_count <= '0;
                            r_drop  <= 1'b0;
                        end else begin
                            r_which <= r_which + sqs_pkg::WHICH_W'(1);
                        end
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
        if (w_hit) begin
            r_result.quantile_value <= w_head;
            r_result.which          <= r_which;
            r_result.overflow       <= r_drop;
            r_result.end_of_run     <= (r_which == sqs_pkg::WHICH_Q3);
        end
    end

    assign busy     = (r_state == S_DRAIN);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// File: sv/sqs_checker.sv
// Port-level checks for the sample quartile selector, bound to the top level.
module sqs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input sqs_pkg::t_in_item  i_item,
    input logic               busy,
    input logic               o_strobe,
    input sqs_pkg::t_out_item o_result
);

    // A transaction taken while idle produces no result in the next cycle
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result strobe right after an accepted transaction");

    // A closing transaction starts the readout
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.last) |=> busy)
        else $error("busy not raised after closing transaction");

    // Results before the last of a run come while still busy
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.end_of_run) |-> busy)
        else $error("intermediate result while idle");

    // The end of a run is followed by a quiet cycle
    a_end_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.end_of_run) |=> !o_strobe)
        else $error("result right after end of run");

endmodule

bind sample_quartile_selector sqs_checker u_sqs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
